/* hdl/fpe_pkg.sv */
`timescale 1ns / 1ps
package fpe_pkg;

  // table geometry
  localparam int MAX_POLOIDAL = 15;
  localparam int MAX_TOROIDAL = 15;
  localparam int SLOTS        = 2 * MAX_TOROIDAL + 1;
  localparam int DEPTH        = (MAX_POLOIDAL + 1) * SLOTS;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int M_W          = $clog2(MAX_POLOIDAL + 1);
  localparam int T_W          = $clog2(MAX_TOROIDAL + 1);
  localparam int I_W          = $clog2(SLOTS);
  localparam int N_W          = I_W + 1;
  localparam int K_W          = N_W + 8;

  // datapath widths
  localparam int TRIG_W = 18;
  localparam int PP_W   = 32 + TRIG_W;
  localparam int PROD_W = PP_W + K_W;
  localparam int RND_W  = PROD_W - 16;
  localparam int ACC_W  = 60;
  localparam int OUT_W  = 48;

  // fixed point constants
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;

  // horner steps, cosine k = 182,132,90,56,30,12,2 and sine k = 156,110,72,42,20,6;
  // the first sine step is empty, so its reciprocal is zero
  localparam int HSTEPS = 7;
  localparam logic [32:0] COS_MAGIC [HSTEPS] = '{
    33'(((65'd1 << 40) + 65'd181) / 65'd182),
    33'(((65'd1 << 40) + 65'd131) / 65'd132),
    33'(((65'd1 << 39) + 65'd89) / 65'd90),
    33'(((65'd1 << 38) + 65'd55) / 65'd56),
    33'(((65'd1 << 37) + 65'd29) / 65'd30),
    33'(((65'd1 << 36) + 65'd11) / 65'd12),
    33'(((65'd1 << 33) + 65'd1) / 65'd2)
  };
  localparam int COS_SHIFT [HSTEPS] = '{40, 40, 39, 38, 37, 36, 33};
  localparam logic [32:0] SIN_MAGIC [HSTEPS] = '{
    33'd0,
    33'(((65'd1 << 40) + 65'd155) / 65'd156),
    33'(((65'd1 << 39) + 65'd109) / 65'd110),
    33'(((65'd1 << 39) + 65'd71) / 65'd72),
    33'(((65'd1 << 38) + 65'd41) / 65'd42),
    33'(((65'd1 << 37) + 65'd19) / 65'd20),
    33'(((65'd1 << 35) + 65'd5) / 65'd6)
  };
  localparam int SIN_SHIFT [HSTEPS] = '{40, 40, 39, 39, 38, 37, 35};

  // opcodes and register indexes
  typedef enum logic [1:0] {
    OP_LOAD_SIN = 2'd0,
    OP_LOAD_COS = 2'd1,
    OP_EVAL     = 2'd2
  } op_t;

  localparam logic [3:0] CFG_POLOIDAL  = 4'd0;
  localparam logic [3:0] CFG_TOROIDAL  = 4'd1;
  localparam logic [3:0] CFG_PERIODS   = 4'd2;
  localparam logic [3:0] CFG_SYMMETRIC = 4'd3;

  typedef struct packed {
    op_t                opcode;
    logic [3:0]         mode_m;
    logic [4:0]         mode_n_slot;
    logic signed [31:0] coefficient;
    logic [15:0]        toroidal_angle;
    logic [15:0]        poloidal_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] potential;
    logic signed [OUT_W-1:0] slope_toroidal;
    logic signed [OUT_W-1:0] slope_poloidal;
    logic                    saturated;
  } out_item_t;

  // one term of the series as it travels down the pipeline
  typedef struct packed {
    logic [M_W-1:0]        m;
    logic signed [K_W-1:0] w;
    logic [ADDR_W-1:0]     addr;
    logic                  skip;
    logic                  first;
    logic                  last;
  } term_tag_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    flag;
  } sat_t;

  // next horner value: one minus the step, floored at zero
  function automatic logic [30:0] horner_t(input logic [31:0] sub);
    logic [30:0] res;
    if (sub > 32'(Q30_ONE)) res = '0;
    else res = 31'(32'(Q30_ONE) - sub);
    return res;
  endfunction

  // q30 to q16 with rounding, capped at one
  function automatic logic [16:0] to_q16(input logic [31:0] v);
    logic [32:0] t;
    t = ({1'b0, v} + 33'd8192) >> 14;
    if (t > 33'd65536) return 17'd65536;
    return t[16:0];
  endfunction

  // q40 product rounded half up to q24
  function automatic logic signed [RND_W-1:0] rnd24(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] t;
    t = x + PROD_W'(32768);
    return RND_W'(t >>> 16);
  endfunction

  function automatic sat_t sat48(input logic signed [ACC_W-1:0] v);
    sat_t res;
    if (v > ACC_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
      res.value = {1'b0, {(OUT_W-1){1'b1}}};
      res.flag  = 1'b1;
    end else if (v < -ACC_W'(signed'({1'b0, 1'b1, {(OUT_W-1){1'b0}}}))) begin
      res.value = {1'b1, {(OUT_W-1){1'b0}}};
      res.flag  = 1'b1;
    end else begin
      res.value = OUT_W'(v);
      res.flag  = 1'b0;
    end
    return res;
  endfunction

endpackage

/* hdl/fpe_trig.sv */
`timescale 1ns / 1ps
module fpe_trig (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [15:0]                      in_ang,
  input  fpe_pkg::term_tag_t               in_tag,
  output logic                             out_valid,
  output logic signed [fpe_pkg::TRIG_W-1:0] out_sin,
  output logic signed [fpe_pkg::TRIG_W-1:0] out_cos,
  output fpe_pkg::term_tag_t               out_tag
);

  typedef struct packed {
    fpe_pkg::term_tag_t tag;
    logic [1:0]         q;
    logic [30:0]        x;
    logic [31:0]        x2;
  } trig_carry_t;

  localparam int NS = fpe_pkg::HSTEPS;

  // stage 0: angle within quadrant to q30 radians
  logic               v0_r;
  trig_carry_t        c0_r;
  logic        [44:0] x_prod;
  assign x_prod = 45'(in_ang[13:0]) * 45'(fpe_pkg::HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= in_valid;
    c0_r.tag <= in_tag;
    c0_r.q   <= in_ang[15:14];
    c0_r.x   <= x_prod[44:14];
    c0_r.x2  <= '0;
  end

  // stage 1: square
  logic               v1_r;
  trig_carry_t        c1_r;
  logic        [61:0] sq_prod;
  assign sq_prod = 62'(c0_r.x) * 62'(c0_r.x);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
    c1_r.tag <= c0_r.tag;
    c1_r.q   <= c0_r.q;
    c1_r.x   <= c0_r.x;
    c1_r.x2  <= sq_prod[61:30];
  end

  // horner steps: multiply stage then reciprocal divide stage
  logic        va_r [NS];
  logic        vb_r [NS];
  trig_carry_t ca_r [NS];
  trig_carry_t cb_r [NS];
  logic [31:0] pc_r [NS];
  logic [31:0] ps_r [NS];
  logic [31:0] subc_r [NS];
  logic [31:0] subs_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic        v_in;
    trig_carry_t c_in;
    logic [31:0] subc_in;
    logic [31:0] subs_in;
    logic [30:0] tc;
    logic [30:0] ts;
    logic [62:0] mulc;
    logic [62:0] muls;
    logic [64:0] divc;
    logic [64:0] divs;

    if (j == 0) begin : g_first
      assign v_in    = v1_r;
      assign c_in    = c1_r;
      assign subc_in = '0;
      assign subs_in = '0;
    end else begin : g_next
      assign v_in    = vb_r[j-1];
      assign c_in    = cb_r[j-1];
      assign subc_in = subc_r[j-1];
      assign subs_in = subs_r[j-1];
    end

    assign tc   = fpe_pkg::horner_t(subc_in);
    assign ts   = fpe_pkg::horner_t(subs_in);
    assign mulc = 63'(c_in.x2) * 63'(tc);
    assign muls = 63'(c_in.x2) * 63'(ts);
    assign divc = 65'(pc_r[j]) * 65'(fpe_pkg::COS_MAGIC[j]);
    assign divs = 65'(ps_r[j]) * 65'(fpe_pkg::SIN_MAGIC[j]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
        vb_r[j] <= 1'b0;
      end else begin
        va_r[j] <= v_in;
        vb_r[j] <= va_r[j];
      end
      ca_r[j]   <= c_in;
      pc_r[j]   <= mulc[61:30];
      ps_r[j]   <= muls[61:30];
      cb_r[j]   <= ca_r[j];
      subc_r[j] <= 32'(divc >> fpe_pkg::COS_SHIFT[j]);
      subs_r[j] <= 32'(divs >> fpe_pkg::SIN_SHIFT[j]);
    end
  end

  // final multiply for sine, cosine taken as is
  logic               vf_r;
  trig_carry_t        cf_r;
  logic        [31:0] s_raw_r;
  logic        [31:0] c_raw_r;
  logic        [30:0] tc_fin;
  logic        [30:0] ts_fin;
  logic        [61:0] s_prod;
  assign tc_fin = fpe_pkg::horner_t(subc_r[NS-1]);
  assign ts_fin = fpe_pkg::horner_t(subs_r[NS-1]);
  assign s_prod = 62'(cb_r[NS-1].x) * 62'(ts_fin);

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else vf_r <= vb_r[NS-1];
    cf_r    <= cb_r[NS-1];
    s_raw_r <= s_prod[61:30];
    c_raw_r <= 32'(tc_fin);
  end

  // round to q16 and fold quadrants
  logic signed [fpe_pkg::TRIG_W-1:0] s16;
  logic signed [fpe_pkg::TRIG_W-1:0] c16;
  logic signed [fpe_pkg::TRIG_W-1:0] sin_nxt;
  logic signed [fpe_pkg::TRIG_W-1:0] cos_nxt;
  assign s16 = signed'(fpe_pkg::TRIG_W'(fpe_pkg::to_q16(s_raw_r)));
  assign c16 = signed'(fpe_pkg::TRIG_W'(fpe_pkg::to_q16(c_raw_r)));

  always_comb begin
    unique case (cf_r.q)
      2'd0: begin
        sin_nxt = s16;
        cos_nxt = c16;
      end
      2'd1: begin
        sin_nxt = c16;
        cos_nxt = -s16;
      end
      2'd2: begin
        sin_nxt = -s16;
        cos_nxt = -c16;
      end
      default: begin
        sin_nxt = -c16;
        cos_nxt = s16;
      end
    endcase
  end

  logic                              out_valid_r;
  logic signed [fpe_pkg::TRIG_W-1:0] out_sin_r;
  logic signed [fpe_pkg::TRIG_W-1:0] out_cos_r;
  fpe_pkg::term_tag_t                out_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vf_r;
    out_sin_r <= sin_nxt;
    out_cos_r <= cos_nxt;
    out_tag_r <= cf_r.tag;
  end

  assign out_valid = out_valid_r;
  assign out_sin   = out_sin_r;
  assign out_cos   = out_cos_r;
  assign out_tag   = out_tag_r;

endmodule

/* hdl/fpe_accum.sv */
`timescale 1ns / 1ps
module fpe_accum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              symmetric,
  input  logic signed [fpe_pkg::TRIG_W-1:0] in_sin,
  input  logic signed [fpe_pkg::TRIG_W-1:0] in_cos,
  input  logic signed [31:0]                sin_coef,
  input  logic signed [31:0]                cos_coef,
  input  fpe_pkg::term_tag_t                in_tag,
  output logic                              done,
  output logic signed [fpe_pkg::ACC_W-1:0]  sum_pot,
  output logic signed [fpe_pkg::ACC_W-1:0]  sum_tor,
  output logic signed [fpe_pkg::ACC_W-1:0]  sum_pol
);

  localparam int PP_W   = fpe_pkg::PP_W;
  localparam int PROD_W = fpe_pkg::PROD_W;
  localparam int ACC_W  = fpe_pkg::ACC_W;

  // stage a: coefficient times trig value
  logic signed [31:0]   s_eff;
  logic signed [31:0]   c_eff;
  logic                 va_r;
  fpe_pkg::term_tag_t   ta_r;
  logic signed [PP_W-1:0] pss_r, psc_r, pcs_r, pcc_r;

  assign s_eff = in_tag.skip ? 32'sd0 : sin_coef;
  assign c_eff = (in_tag.skip || symmetric) ? 32'sd0 : cos_coef;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= in_valid;
    ta_r  <= in_tag;
    pss_r <= PP_W'(s_eff) * PP_W'(in_sin);
    psc_r <= PP_W'(s_eff) * PP_W'(in_cos);
    pcs_r <= PP_W'(c_eff) * PP_W'(in_sin);
    pcc_r <= PP_W'(c_eff) * PP_W'(in_cos);
  end

  // stage b: weights
  logic signed [fpe_pkg::K_W-1:0] negw;
  logic signed [fpe_pkg::M_W:0]   mpos;
  logic signed [fpe_pkg::M_W:0]   mneg;
  logic                           vb_r;
  fpe_pkg::term_tag_t             tb_r;
  logic signed [PROD_W-1:0]       p0_r, p1_r, t0_r, t1_r, q0_r, q1_r;

  assign negw = -ta_r.w;
  assign mpos = signed'({1'b0, ta_r.m});
  assign mneg = -mpos;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
    tb_r <= ta_r;
    p0_r <= PROD_W'(pss_r);
    p1_r <= PROD_W'(pcc_r);
    t0_r <= PROD_W'(ta_r.w) * PROD_W'(psc_r);
    t1_r <= PROD_W'(negw) * PROD_W'(pcs_r);
    q0_r <= PROD_W'(mpos) * PROD_W'(psc_r);
    q1_r <= PROD_W'(mneg) * PROD_W'(pcs_r);
  end

  // stage c: round each product and add the pairs
  logic                    vc_r;
  fpe_pkg::term_tag_t      tc_r;
  logic signed [ACC_W-1:0] dp_r, dt_r, dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= vb_r;
    tc_r <= tb_r;
    dp_r <= ACC_W'(fpe_pkg::rnd24(p0_r)) + ACC_W'(fpe_pkg::rnd24(p1_r));
    dt_r <= ACC_W'(fpe_pkg::rnd24(t0_r)) + ACC_W'(fpe_pkg::rnd24(t1_r));
    dq_r <= ACC_W'(fpe_pkg::rnd24(q0_r)) + ACC_W'(fpe_pkg::rnd24(q1_r));
  end

  // stage d: accumulate, restart on the first term
  logic                    done_r;
  logic signed [ACC_W-1:0] acc_p_r, acc_t_r, acc_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= vc_r && tc_r.last;
    if (vc_r) begin
      acc_p_r <= tc_r.first ? dp_r : acc_p_r + dp_r;
      acc_t_r <= tc_r.first ? dt_r : acc_t_r + dt_r;
      acc_q_r <= tc_r.first ? dq_r : acc_q_r + dq_r;
    end
  end

  assign done    = done_r;
  assign sum_pot = acc_p_r;
  assign sum_tor = acc_t_r;
  assign sum_pol = acc_q_r;

endmodule

/* hdl/fpe_scale.sv */
`timescale 1ns / 1ps
module fpe_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [fpe_pkg::ACC_W-1:0]  in_sum,
  output logic                              out_valid,
  output fpe_pkg::sat_t                     out_res
);

  localparam int ACC_W = fpe_pkg::ACC_W;

  // stage 1: magnitude split in two halves, each times 2*pi in q29
  logic             neg;
  logic [ACC_W-1:0] mag;
  logic             v1_r;
  logic             neg_r;
  logic             big_r;
  logic [54:0]      ph_r;
  logic [54:0]      pl_r;

  assign neg = in_sum[ACC_W-1];
  assign mag = neg ? unsigned'(-in_sum) : unsigned'(in_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_valid;
    neg_r <= neg;
    big_r <= |mag[ACC_W-1:46];
    ph_r  <= 55'(mag[45:23]) * 55'(fpe_pkg::TWO_PI_Q29);
    pl_r  <= 55'(mag[22:0]) * 55'(fpe_pkg::TWO_PI_Q29);
  end

  // stage 2: combine, round, restore sign and clamp
  logic [55:0]             cval;
  logic signed [ACC_W-1:0] sval;
  fpe_pkg::sat_t           res_nxt;

  assign cval = 56'(ph_r) + 56'(pl_r >> 23) + 56'd32;

  always_comb begin
    sval = neg_r ? -signed'(ACC_W'(cval[55:6])) : signed'(ACC_W'(cval[55:6]));
    if (big_r) begin
      res_nxt.flag  = 1'b1;
      res_nxt.value = neg_r ? {1'b1, {(fpe_pkg::OUT_W-1){1'b0}}}
                            : {1'b0, {(fpe_pkg::OUT_W-1){1'b1}}};
    end else begin
      res_nxt = fpe_pkg::sat48(sval);
    end
  end

  logic          v2_r;
  fpe_pkg::sat_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    res_r <= res_nxt;
  end

  assign out_valid = v2_r;
  assign out_res   = res_r;

endmodule

/* hdl/fourier_potential_evaluator_core.sv */
`timescale 1ns / 1ps
// double fourier series evaluator with loadable sine and cosine tables
// input channel: a beat is taken when start is high and busy is low.
//   opcode 0 and 1 write one in-range sine or cosine coefficient in that cycle; busy stays low
//   and no result follows. opcode 2 evaluates the series at (phi, theta).
// result channel: out_strobe marks out_data for one cycle; there is no back pressure.
// config channel: cfg_ready is always high; write only while busy is low.
// an evaluation walks every (m, slot) pair, one term per cycle, through the
//   sin/cos horner pipeline (18 stages), a coefficient read, a 4 stage product and
//   accumulate pipe and a 2 stage 2*pi scaler.
// an evaluate beat issues (pm+1)*(2*nt+1) terms, pm and nt the mode
//   counts in use; busy stays high until the result is given, so a new
//   evaluation is taken only after the last one ends (full tables are 16 x 31).
// load beats do not raise busy and may follow back to back.
// reset clears the sequencer, pipeline valid bits and registers to
//   poloidal 0, toroidal 0, field periods 1, symmetric on.
// coefficient tables are not cleared by reset; load entries before use.
module fourier_potential_evaluator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fpe_pkg::in_item_t   in_data,
  output logic                out_strobe,
  output fpe_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int M_W    = fpe_pkg::M_W;
  localparam int T_W    = fpe_pkg::T_W;
  localparam int I_W    = fpe_pkg::I_W;
  localparam int N_W    = fpe_pkg::N_W;
  localparam int K_W    = fpe_pkg::K_W;
  localparam int ADDR_W = fpe_pkg::ADDR_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_t;

  // configuration registers
  logic [3:0] pol_cfg_r;
  logic [3:0] tor_cfg_r;
  logic [6:0] fp_cfg_r;
  logic       sym_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_cfg_r <= '0;
      tor_cfg_r <= '0;
      fp_cfg_r  <= 7'd1;
      sym_cfg_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpe_pkg::CFG_POLOIDAL:  pol_cfg_r <= cfg_wdata[3:0];
        fpe_pkg::CFG_TOROIDAL:  tor_cfg_r <= cfg_wdata[3:0];
        fpe_pkg::CFG_PERIODS:   fp_cfg_r  <= cfg_wdata[6:0];
        fpe_pkg::CFG_SYMMETRIC: sym_cfg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // coefficient tables
  logic signed [31:0] sine_mem [fpe_pkg::DEPTH];
  logic signed [31:0] cosine_mem [fpe_pkg::DEPTH];

  logic              accept;
  logic              load_ok;
  logic [ADDR_W-1:0] load_addr;

  assign accept  = start && !busy;
  assign load_ok = (32'(in_data.mode_m) <= fpe_pkg::MAX_POLOIDAL) &&
                   (32'(in_data.mode_n_slot) < fpe_pkg::SLOTS);
  assign load_addr = ADDR_W'(32'(in_data.mode_m) * fpe_pkg::SLOTS +
                             32'(in_data.mode_n_slot));

  // sequencer over (m, slot)
  state_t          state_r;
  logic [M_W-1:0]  m_r;
  logic [I_W-1:0]  i_r;
  logic [M_W-1:0]  pm_r;
  logic [T_W-1:0]  nt_r;
  logic [I_W-1:0]  imax_r;
  logic [15:0]     theta_r;
  logic [15:0]     phi_r;
  logic            first_r;
  logic            out_strobe_r;
  fpe_pkg::out_item_t out_data_r;

  logic [M_W-1:0] pm_use;
  logic [T_W-1:0] nt_use;
  logic           last_term;
  logic           scale_valid;
  fpe_pkg::sat_t  tor_res;
  fpe_pkg::sat_t  pol_res;
  fpe_pkg::sat_t  pot_d2_r;

  assign pm_use = (32'(pol_cfg_r) > fpe_pkg::MAX_POLOIDAL) ?
                  M_W'(fpe_pkg::MAX_POLOIDAL) : M_W'(pol_cfg_r);
  assign nt_use = (32'(tor_cfg_r) > fpe_pkg::MAX_TOROIDAL) ?
                  T_W'(fpe_pkg::MAX_TOROIDAL) : T_W'(tor_cfg_r);
  assign last_term = (m_r == pm_r) && (i_r == imax_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_WAIT) && scale_valid;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_data.opcode == fpe_pkg::OP_EVAL) begin
            state_r <= ST_ISSUE;
            first_r <= 1'b1;
          end
        end
        ST_ISSUE: begin
          first_r <= 1'b0;
          if (last_term) state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (scale_valid) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    // counters and latched point
    if (state_r == ST_IDLE) begin
      m_r     <= '0;
      i_r     <= '0;
      pm_r    <= pm_use;
      nt_r    <= nt_use;
      imax_r  <= I_W'({nt_use, 1'b0});
      theta_r <= in_data.poloidal_angle;
      phi_r   <= in_data.toroidal_angle;
    end else if (state_r == ST_ISSUE) begin
      if (i_r == imax_r) begin
        i_r <= '0;
        m_r <= m_r + M_W'(1);
      end else begin
        i_r <= i_r + I_W'(1);
      end
    end
    out_data_r.potential      <= pot_d2_r.value;
    out_data_r.slope_toroidal <= tor_res.value;
    out_data_r.slope_poloidal <= pol_res.value;
    out_data_r.saturated      <= pot_d2_r.flag | tor_res.flag | pol_res.flag;
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // table writes
  always_ff @(posedge clk) begin
    if (accept && load_ok && in_data.opcode == fpe_pkg::OP_LOAD_SIN)
      sine_mem[load_addr] <= in_data.coefficient;
    if (accept && load_ok && in_data.opcode == fpe_pkg::OP_LOAD_COS)
      cosine_mem[load_addr] <= in_data.coefficient;
  end

  // issue stage: angle and weight of the current term
  logic signed [N_W-1:0] n_cur;
  logic signed [K_W-1:0] k_cur;
  logic [15:0]           ang_cur;
  logic                  iss_valid_r;
  logic [15:0]           iss_ang_r;
  fpe_pkg::term_tag_t    iss_tag_r;

  assign n_cur   = signed'(N_W'(i_r)) - signed'(N_W'(nt_r));
  assign k_cur   = K_W'(n_cur) * K_W'(signed'({1'b0, fp_cfg_r}));
  assign ang_cur = 16'(32'(m_r) * 32'(theta_r)) -
                   16'(32'(k_cur) * signed'(32'(phi_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) iss_valid_r <= 1'b0;
    else iss_valid_r <= state_r == ST_ISSUE;
    iss_ang_r       <= ang_cur;
    iss_tag_r.m     <= m_r;
    iss_tag_r.w     <= -k_cur;
    iss_tag_r.addr  <= ADDR_W'(32'(m_r) * fpe_pkg::SLOTS + 32'(i_r));
    iss_tag_r.skip  <= (m_r == '0) && (n_cur <= 0);
    iss_tag_r.first <= first_r;
    iss_tag_r.last  <= last_term;
  end

  // sine and cosine of the term angle
  logic                              trig_valid;
  logic signed [fpe_pkg::TRIG_W-1:0] trig_sin;
  logic signed [fpe_pkg::TRIG_W-1:0] trig_cos;
  fpe_pkg::term_tag_t                trig_tag;

  fpe_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (iss_valid_r),
    .in_ang    (iss_ang_r),
    .in_tag    (iss_tag_r),
    .out_valid (trig_valid),
    .out_sin   (trig_sin),
    .out_cos   (trig_cos),
    .out_tag   (trig_tag)
  );

  // coefficient read, trig values held alongside
  logic                              rd_valid_r;
  logic signed [31:0]                rd_sin_coef_r;
  logic signed [31:0]                rd_cos_coef_r;
  logic signed [fpe_pkg::TRIG_W-1:0] rd_sin_r;
  logic signed [fpe_pkg::TRIG_W-1:0] rd_cos_r;
  fpe_pkg::term_tag_t                rd_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_valid_r <= 1'b0;
    else rd_valid_r <= trig_valid;
    rd_sin_coef_r <= sine_mem[trig_tag.addr];
    rd_cos_coef_r <= cosine_mem[trig_tag.addr];
    rd_sin_r      <= trig_sin;
    rd_cos_r      <= trig_cos;
    rd_tag_r      <= trig_tag;
  end

  // products and sums
  logic                              acc_done;
  logic signed [fpe_pkg::ACC_W-1:0]  sum_pot;
  logic signed [fpe_pkg::ACC_W-1:0]  sum_tor;
  logic signed [fpe_pkg::ACC_W-1:0]  sum_pol;

  fpe_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_valid_r),
    .symmetric (sym_cfg_r),
    .in_sin    (rd_sin_r),
    .in_cos    (rd_cos_r),
    .sin_coef  (rd_sin_coef_r),
    .cos_coef  (rd_cos_coef_r),
    .in_tag    (rd_tag_r),
    .done      (acc_done),
    .sum_pot   (sum_pot),
    .sum_tor   (sum_tor),
    .sum_pol   (sum_pol)
  );

  // 2*pi scaling of the slopes, potential clamped in step
  logic pol_valid;
  fpe_pkg::sat_t pot_d1_r;

  fpe_scale u_scale_tor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_done),
    .in_sum    (sum_tor),
    .out_valid (scale_valid),
    .out_res   (tor_res)
  );

  fpe_scale u_scale_pol (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_done),
    .in_sum    (sum_pol),
    .out_valid (pol_valid),
    .out_res   (pol_res)
  );

  always_ff @(posedge clk) begin
    pot_d1_r <= fpe_pkg::sat48(sum_pot);
    pot_d2_r <= pot_d1_r;
  end

  // checks
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a running evaluation");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("evaluation ended without a result");

  a_scalers_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    scale_valid == pol_valid)
    else $error("slope scalers out of step");

  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> state_r == ST_WAIT)
    else $error("accumulator finished outside of an evaluation");

endmodule
